>>> hdl/rsrd_pkg.sv
// shared types, codes and helpers of the rgbe scanline decoder
package rsrd_pkg;

    localparam int          WIDTH_DEFAULT = 16384;
    localparam logic [14:0] WIDTH_RESET   = 15'd1024;
    localparam logic [14:0] MIN_NEW_WIDTH = 15'd8;
    localparam logic [14:0] MAX_NEW_WIDTH = 15'h7fff;
    localparam logic [7:0]  RUN_FLAG      = 8'd128;
    localparam logic [7:0]  RUN_MASK      = 8'd127;
    localparam logic [7:0]  HDR_MARK      = 8'd2;
    localparam logic [23:0] REPEAT_MARK   = 24'h010101;
    localparam logic [1:0]  SHIFT_CAP     = 2'd3;
    localparam logic [1:0]  LAST_PLANE    = 2'd3;
    localparam logic [1:0]  LAST_PIX_BYTE = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [2:0] LANE_PIXEL = 3'd4;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_END     = 2'd2;

    typedef enum logic [3:0] {
        PH_START, PH_HDR1, PH_HDR2, PH_HDR3, PH_OLD,
        PH_CODE, PH_RUNVAL, PH_LIT, PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [13:0] pixel_x;
        logic [14:0] fill_count;
        logic [2:0]  lane;
        logic [31:0] fill_value;
        logic        line_end;
        logic [1:0]  error;
    } t_cmd;

    // width limited to 1..maxw
    function automatic logic [14:0] eff_width(input logic [14:0] v, input logic [14:0] maxw);
        logic [14:0] w;
        w = (v == 15'd0) ? 15'd1 : v;
        if (w > maxw) begin
            w = maxw;
        end
        return w;
    endfunction

endpackage

>>> hdl/rsrd_front.sv
// front end: byte parser and fill command generator
module rsrd_front #(
    parameter int MAX_WIDTH = rsrd_pkg::WIDTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  logic             i_cfg_we,
    input  logic [14:0]      i_cfg_data,
    output logic             o_emit,
    output rsrd_pkg::t_cmd   o_cmd
);

    localparam logic [14:0] MaxW = 15'(MAX_WIDTH);

    rsrd_pkg::t_phase r_phase, n_phase;
    logic [23:0] r_hdr, n_hdr;
    logic [1:0]  r_plane, n_plane;
    logic [14:0] r_pos, n_pos;
    logic [7:0]  r_left, n_left;
    logic [6:0]  r_run, n_run;
    logic [1:0]  r_pbi, n_pbi;
    logic [31:0] r_last, n_last;
    logic [1:0]  r_shift, n_shift;
    logic [14:0] r_width, n_width;

    logic        do_restart;
    logic [14:0] rem;
    logic [15:0] rep_raw;
    logic        rep_over;
    logic [14:0] rep_cnt;
    logic [14:0] run_cnt;
    logic [15:0] new_pos;
    logic [7:0]  left_dec;
    logic [31:0] pix;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsrd_pkg::PH_START;
            r_hdr   <= '0;
            r_plane <= '0;
            r_pos   <= '0;
            r_left  <= '0;
            r_run   <= '0;
            r_pbi   <= '0;
            r_last  <= '0;
            r_shift <= '0;
            r_width <= rsrd_pkg::eff_width(rsrd_pkg::WIDTH_RESET, MaxW);
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_plane <= n_plane;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_run   <= n_run;
            r_pbi   <= n_pbi;
            r_last  <= n_last;
            r_shift <= n_shift;
            r_width <= n_width;
        end
    end

    // shared arithmetic
    always_comb begin
        rem      = (r_pos < r_width) ? (r_width - r_pos) : 15'd0;
        case (r_shift)
            2'd0:    rep_raw = {8'd0, i_byte};
            2'd1:    rep_raw = {i_byte, 8'd0};
            default: rep_raw = 16'd0;
        endcase
        rep_over = ((r_shift >= 2'd2) && (i_byte != 8'd0)) || (rep_raw > {1'b0, rem});
        rep_cnt  = rep_over ? rem : rep_raw[14:0];
        run_cnt  = ({8'd0, r_run} > rem) ? rem : {8'd0, r_run};
        left_dec = (r_left != 8'd0) ? (r_left - 8'd1) : 8'd0;
        pix      = {i_byte, r_hdr};
    end

    // next state and command
    always_comb begin
        n_phase    = r_phase;
        n_hdr      = r_hdr;
        n_plane    = r_plane;
        n_pos      = r_pos;
        n_left     = r_left;
        n_run      = r_run;
        n_pbi      = r_pbi;
        n_last     = r_last;
        n_shift    = r_shift;
        n_width    = r_width;
        do_restart = 1'b0;
        new_pos    = 16'd0;
        o_emit     = 1'b0;
        o_cmd      = '0;

        if (i_cfg_we) begin
            n_width    = rsrd_pkg::eff_width(i_cfg_data, MaxW);
            do_restart = 1'b1;
        end else if (i_valid && i_end) begin
            // early end of stream aborts a started line
            if (r_phase != rsrd_pkg::PH_START) begin
                o_emit           = 1'b1;
                o_cmd.pixel_x    = r_pos[13:0];
                o_cmd.line_end   = 1'b1;
                o_cmd.error      = rsrd_pkg::ERR_END;
                do_restart       = 1'b1;
            end
        end else if (i_valid) begin
            case (r_phase)
                rsrd_pkg::PH_START: begin
                    n_plane = '0;
                    n_pos   = '0;
                    n_left  = '0;
                    n_run   = '0;
                    n_shift = '0;
                    if (r_width >= rsrd_pkg::MIN_NEW_WIDTH && r_width <= rsrd_pkg::MAX_NEW_WIDTH
                        && i_byte == rsrd_pkg::HDR_MARK) begin
                        n_hdr   = '0;
                        n_pbi   = '0;
                        n_phase = rsrd_pkg::PH_HDR1;
                    end else begin
                        n_hdr   = {16'd0, i_byte};
                        n_pbi   = 2'd1;
                        n_phase = rsrd_pkg::PH_OLD;
                    end
                end
                rsrd_pkg::PH_HDR1: begin
                    n_hdr   = {16'd0, i_byte};
                    n_phase = rsrd_pkg::PH_HDR2;
                end
                rsrd_pkg::PH_HDR2: begin
                    n_hdr[15:8] = i_byte;
                    n_phase     = rsrd_pkg::PH_HDR3;
                end
                rsrd_pkg::PH_HDR3: begin
                    n_hdr = '0;
                    if (r_hdr[7:0] != rsrd_pkg::HDR_MARK || r_hdr[15] != 1'b0) begin
                        // not a new-format header: it is pixel 0
                        n_last           = {i_byte, r_hdr[15:0], rsrd_pkg::HDR_MARK};
                        n_shift          = '0;
                        n_pbi            = '0;
                        n_pos            = 15'd1;
                        n_phase          = rsrd_pkg::PH_OLD;
                        o_emit           = 1'b1;
                        o_cmd.fill_count = 15'd1;
                        o_cmd.lane       = rsrd_pkg::LANE_PIXEL;
                        o_cmd.fill_value = {i_byte, r_hdr[15:0], rsrd_pkg::HDR_MARK};
                    end else begin
                        n_plane = '0;
                        n_pos   = '0;
                        n_phase = rsrd_pkg::PH_CODE;
                    end
                end
                rsrd_pkg::PH_OLD: begin
                    if (r_pbi < rsrd_pkg::LAST_PIX_BYTE) begin
                        n_hdr[{r_pbi, 3'b000} +: 8] = r_hdr[{r_pbi, 3'b000} +: 8] | i_byte;
                        n_pbi = r_pbi + 2'd1;
                    end else begin
                        n_hdr = '0;
                        n_pbi = '0;
                        if (r_hdr == rsrd_pkg::REPEAT_MARK) begin
                            // repeat marker: last pixel, count grows by a byte per marker
                            if (r_shift != rsrd_pkg::SHIFT_CAP) begin
                                n_shift = r_shift + 2'd1;
                            end
                            if (i_byte != 8'd0) begin
                                new_pos          = {1'b0, r_pos} + {1'b0, rep_cnt};
                                n_pos            = new_pos[14:0];
                                o_emit           = 1'b1;
                                o_cmd.pixel_x    = r_pos[13:0];
                                o_cmd.fill_count = rep_cnt;
                                o_cmd.lane       = rsrd_pkg::LANE_PIXEL;
                                o_cmd.fill_value = r_last;
                                o_cmd.error      = rep_over ? rsrd_pkg::ERR_OVERRUN
                                                            : rsrd_pkg::ERR_OK;
                                if (new_pos >= {1'b0, r_width}) begin
                                    do_restart     = 1'b1;
                                    o_cmd.line_end = 1'b1;
                                end
                            end
                        end else begin
                            n_last           = pix;
                            n_shift          = '0;
                            new_pos          = {1'b0, r_pos} + 16'd1;
                            n_pos            = new_pos[14:0];
                            o_emit           = 1'b1;
                            o_cmd.pixel_x    = r_pos[13:0];
                            o_cmd.fill_count = 15'd1;
                            o_cmd.lane       = rsrd_pkg::LANE_PIXEL;
                            o_cmd.fill_value = pix;
                            if (new_pos >= {1'b0, r_width}) begin
                                do_restart     = 1'b1;
                                o_cmd.line_end = 1'b1;
                            end
                        end
                    end
                end
                rsrd_pkg::PH_CODE: begin
                    if (i_byte > rsrd_pkg::RUN_FLAG) begin
                        n_run   = 7'(i_byte & rsrd_pkg::RUN_MASK);
                        n_phase = rsrd_pkg::PH_RUNVAL;
                    end else if (i_byte != 8'd0) begin
                        n_left  = i_byte;
                        n_phase = rsrd_pkg::PH_LIT;
                    end
                end
                rsrd_pkg::PH_RUNVAL: begin
                    new_pos          = {1'b0, r_pos} + {1'b0, run_cnt};
                    n_pos            = new_pos[14:0];
                    o_emit           = 1'b1;
                    o_cmd.pixel_x    = r_pos[13:0];
                    o_cmd.fill_count = run_cnt;
                    o_cmd.lane       = {1'b0, r_plane};
                    o_cmd.fill_value = {24'd0, i_byte};
                    o_cmd.error      = ({8'd0, r_run} > rem) ? rsrd_pkg::ERR_OVERRUN
                                                             : rsrd_pkg::ERR_OK;
                    if (new_pos >= {1'b0, r_width}) begin
                        n_last[{r_plane, 3'b000} +: 8] = i_byte;
                        if (r_plane == rsrd_pkg::LAST_PLANE) begin
                            do_restart     = 1'b1;
                            o_cmd.line_end = 1'b1;
                        end else begin
                            n_plane = r_plane + 2'd1;
                            n_pos   = '0;
                            n_phase = rsrd_pkg::PH_CODE;
                        end
                    end else begin
                        n_phase = rsrd_pkg::PH_CODE;
                    end
                end
                rsrd_pkg::PH_LIT: begin
                    new_pos          = {1'b0, r_pos} + 16'd1;
                    n_pos            = new_pos[14:0];
                    n_left           = left_dec;
                    o_emit           = 1'b1;
                    o_cmd.pixel_x    = r_pos[13:0];
                    o_cmd.fill_count = 15'd1;
                    o_cmd.lane       = {1'b0, r_plane};
                    o_cmd.fill_value = {24'd0, i_byte};
                    if (new_pos >= {1'b0, r_width}) begin
                        n_last[{r_plane, 3'b000} +: 8] = i_byte;
                        if (left_dec != 8'd0) begin
                            // surplus literal bytes are skipped
                            o_cmd.error    = rsrd_pkg::ERR_OVERRUN;
                            o_cmd.line_end = (r_plane == rsrd_pkg::LAST_PLANE);
                            n_phase        = rsrd_pkg::PH_SKIP;
                        end else if (r_plane == rsrd_pkg::LAST_PLANE) begin
                            do_restart     = 1'b1;
                            o_cmd.line_end = 1'b1;
                        end else begin
                            n_plane = r_plane + 2'd1;
                            n_pos   = '0;
                            n_phase = rsrd_pkg::PH_CODE;
                        end
                    end else if (left_dec == 8'd0) begin
                        n_phase = rsrd_pkg::PH_CODE;
                    end
                end
                rsrd_pkg::PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        if (r_plane == rsrd_pkg::LAST_PLANE) begin
                            do_restart = 1'b1;
                        end else begin
                            n_plane = r_plane + 2'd1;
                            n_pos   = '0;
                            n_phase = rsrd_pkg::PH_CODE;
                        end
                    end
                end
                default: begin
                    do_restart = 1'b1;
                end
            endcase
        end

        // line restart keeps the last pixel and the width
        if (do_restart) begin
            n_phase = rsrd_pkg::PH_START;
            n_hdr   = '0;
            n_plane = '0;
            n_pos   = '0;
            n_left  = '0;
            n_run   = '0;
            n_pbi   = '0;
            n_shift = '0;
        end
    end

`ifndef SYNTHESIS
    a_skip_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rsrd_pkg::PH_SKIP) |-> (r_left != 8'd0))
        else $error("skip phase with no bytes left");
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_cmd.error != rsrd_pkg::ERR_END) |-> (o_cmd.fill_count != 15'd0))
        else $error("fill word with zero count");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rsrd_pkg::PH_CODE || r_phase == rsrd_pkg::PH_RUNVAL
         || r_phase == rsrd_pkg::PH_LIT) |-> (r_pos < r_width))
        else $error("plane position past line width");
`endif

endmodule

>>> hdl/rsrd_fifo.sv
// back end: command queue that drives the result ports
module rsrd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  rsrd_pkg::t_cmd i_cmd,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_empty,
    output rsrd_pkg::t_cmd o_cmd
);

    localparam logic [rsrd_pkg::Q_AW:0] Depth = (rsrd_pkg::Q_AW + 1)'(rsrd_pkg::Q_DEPTH);

    rsrd_pkg::t_cmd r_mem [rsrd_pkg::Q_DEPTH];
    logic [rsrd_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [rsrd_pkg::Q_AW:0]   r_count;
    logic wr_ok, rd_ok;

    assign o_full  = (r_count == Depth);
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Depth)
        else $error("queue level beyond depth");
    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && !rd_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue level missed a word");
`endif

endmodule

>>> hdl/rgbe_scanline_rle_decoder.sv
// top level of the rgbe scanline run-length decoder
//
//  channel   direction  handshake             payload
//  input     in         push / full           i_in_byte, i_stream_end
//  result    out        empty / pop           o_pixel_x .. o_error
//  config    in         i_cfg_valid / ready   i_cfg_data (scan width)
//
// one byte per cycle while full is low; the parser updates its state at the edge that
// takes the byte and writes the fill word into a four-word queue at that same edge
// a fill word for an empty queue shows on result ports the cycle after its byte is taken
// full rises when four words wait unread and holds the input even while pop is high
// no clearing pass after reset
// a width write restarts the line and keeps the last pixel
module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH = rsrd_pkg::WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_stream_end,
    output logic        empty,
    input  logic        pop,
    output logic [13:0] o_pixel_x,
    output logic [14:0] o_fill_count,
    output logic [2:0]  o_lane,
    output logic [31:0] o_fill_value,
    output logic        o_line_end,
    output logic [1:0]  o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data
);

    logic           acc;
    logic           emit;
    rsrd_pkg::t_cmd cmd;
    rsrd_pkg::t_cmd head;

    assign o_cfg_ready = 1'b1;
    assign acc         = push && !full;

    // parser
    rsrd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (acc),
        .i_byte     (i_in_byte),
        .i_end      (i_stream_end),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_emit     (emit),
        .o_cmd      (cmd)
    );

    // result queue
    rsrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (emit),
        .i_cmd   (cmd),
        .i_rd    (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head)
    );

    assign o_pixel_x    = head.pixel_x;
    assign o_fill_count = head.fill_count;
    assign o_lane       = head.lane;
    assign o_fill_value = head.fill_value;
    assign o_line_end   = head.line_end;
    assign o_error      = head.error;

endmodule
